/* rtl/length_prefixed_message_queue_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed message queue core
// Concurrent checks clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_QUEUE_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define LPMQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define LPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPMQ_ASSERT_SAME(lbl, ante, cons, msg)
`define LPMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/lpmq_pkg.sv */
// ---------------------------------------------------------------------------
// Length-prefixed message queue package
// Sizes, command codes, memory request type and buffer addressing.
// ---------------------------------------------------------------------------
package lpmq_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int RING_DEPTH = 4;
  localparam int MSG_BYTES  = 256;

  // One spare buffer per slot holds the message being assembled.
  localparam int PHYS_BUFS  = RING_DEPTH + 1;
  localparam int PTR_W      = $clog2(PHYS_BUFS);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int BUF_COUNT  = SLOT_COUNT * PHYS_BUFS;
  localparam int BUF_IDX_W  = $clog2(BUF_COUNT);
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = BUF_IDX_W + BYTE_W;
  localparam int MEM_DEPTH  = BUF_COUNT * 256;
  localparam int LEN_W      = 9;

  localparam logic [2:0] CMD_RX      = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_POP     = 3'd2;
  localparam logic [2:0] CMD_RESET   = 3'd3;
  localparam logic [2:0] CMD_OUTCOME = 3'd4;
  localparam logic [2:0] CMD_CLOSED  = 3'd5;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Advance a ring pointer over the physical buffers of a slot.
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(PHYS_BUFS - 1)) r = '0;
    else r = p + ptr_t'(1);
    return r;
  endfunction

  // Flat buffer number of a slot's physical buffer.
  function automatic logic [BUF_IDX_W-1:0] buf_index(input logic [1:0] s, input ptr_t b);
    logic [BUF_IDX_W+PTR_W:0] t;
    t = (BUF_IDX_W+PTR_W+1)'(s) * (BUF_IDX_W+PTR_W+1)'(PHYS_BUFS)
        + (BUF_IDX_W+PTR_W+1)'(b);
    return t[BUF_IDX_W-1:0];
  endfunction

endpackage

/* rtl/lpmq_byte_ram.sv */
// ---------------------------------------------------------------------------
// Message byte store
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module lpmq_byte_ram (
  input  logic              clk,
  input  lpmq_pkg::mem_req_t req,
  output logic [7:0]        q
);

  logic [7:0] mem [lpmq_pkg::MEM_DEPTH];

  // Write and read in the same clocked block; items never overlap on one entry.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q <= mem[req.rd_addr];
    end
  end

endmodule

/* rtl/length_prefixed_message_queue_core.sv */
// ---------------------------------------------------------------------------
// Length-prefixed message queue core
// Deframes per-slot byte streams and queues complete messages per slot.
// ---------------------------------------------------------------------------
// Input channel: cmd, slot, value, connect_ok with in_valid / in_stall.
// Output channel: one result word per input word, out_valid / out_stall.
// A word is taken at the clock edge where valid is high and stall is low.
// At acceptance of an input word the slot state and the
// byte memory write are updated and the head byte read is issued; once the
// output register is free, the registered memory data and status form the
// result word. A new input word is taken only after the result of the last
// one has been loaded into the output register; in_stall is high meanwhile.
// Messages are assembled in place in a spare buffer per slot, so completing
// a message costs no copy.
// Reset clears every slot: all flags, frame state and queues; no memory
// clearing is needed. When the receiver stalls, one result is held in the
// output register and one further input word may be accepted, its result
// waiting in flight; in_stall then stays high until the held result is taken.
// ---------------------------------------------------------------------------
`include "length_prefixed_message_queue_core_defines.svh"

module length_prefixed_message_queue_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [1:0] slot,
  input  logic [7:0] value,
  input  logic       connect_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_byte,
  output logic [8:0] head_length,
  output logic       queue_empty,
  output logic       message_done,
  output logic       is_connected,
  output logic       data_ready,
  output logic       slot_fault,
  output logic       remote_closed,
  output logic       any_data,
  output logic       any_error
);

  localparam int NS = lpmq_pkg::SLOT_COUNT;

  // Per-slot control state.
  logic                      conn [NS];
  logic                      err [NS];
  logic                      closed [NS];
  logic                      factive [NS];
  logic [8:0]                fexp [NS];
  logic [8:0]                frecv [NS];
  lpmq_pkg::ptr_t            head [NS];
  lpmq_pkg::ptr_t            tail [NS];
  logic [lpmq_pkg::CNT_W-1:0] count [NS];

  logic                      conn_next [NS];
  logic                      err_next [NS];
  logic                      closed_next [NS];
  logic                      factive_next [NS];
  logic [8:0]                fexp_next [NS];
  logic [8:0]                frecv_next [NS];
  lpmq_pkg::ptr_t            head_next [NS];
  lpmq_pkg::ptr_t            tail_next [NS];
  logic [lpmq_pkg::CNT_W-1:0] count_next [NS];

  // Message lengths, one per physical buffer.
  logic [8:0] lengths [lpmq_pkg::BUF_COUNT];
  logic       len_we;
  logic [lpmq_pkg::BUF_IDX_W-1:0] len_waddr;

  // Item in flight between acceptance and result.
  logic       busy;
  logic       p_slot_ok;
  logic [1:0] p_slot;
  logic       p_read;
  logic [7:0] p_val;
  logic       p_empty;
  logic       p_done;

  logic       accept;
  logic       slot_ok;
  logic       done_c;
  logic       empty_c;
  logic       read_c;
  logic       load_out;
  lpmq_pkg::mem_req_t mreq;
  logic [7:0] mem_q;
  logic [8:0] hlen;
  logic       any_d;
  logic       any_e;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign slot_ok  = {1'b0, slot} < 3'(NS);
  assign load_out = busy && (!out_valid || !out_stall);

  lpmq_byte_ram u_ram (
    .clk (clk),
    .req (mreq),
    .q   (mem_q)
  );

  // Next slot state and memory requests for the accepted word.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      conn_next[i]    = conn[i];
      err_next[i]     = err[i];
      closed_next[i]  = closed[i];
      factive_next[i] = factive[i];
      fexp_next[i]    = fexp[i];
      frecv_next[i]   = frecv[i];
      head_next[i]    = head[i];
      tail_next[i]    = tail[i];
      count_next[i]   = count[i];
    end
    mreq      = '0;
    len_we    = 1'b0;
    len_waddr = lpmq_pkg::buf_index(slot, tail[slot]);
    done_c    = 1'b0;
    empty_c   = 1'b0;
    read_c    = 1'b0;
    if (accept && slot_ok) begin
      unique case (cmd)
        lpmq_pkg::CMD_RX: begin
          if (conn[slot]) begin
            if (!factive[slot]) begin
              fexp_next[slot]    = (value == 8'd0) ? 9'd256 : {1'b0, value};
              frecv_next[slot]   = '0;
              factive_next[slot] = 1'b1;
            end else begin
              mreq.wr_en   = frecv[slot] < 9'(lpmq_pkg::MSG_BYTES);
              mreq.wr_addr = {lpmq_pkg::buf_index(slot, tail[slot]), frecv[slot][7:0]};
              mreq.wr_data = value;
              frecv_next[slot] = frecv[slot] + 9'd1;
              if (frecv[slot] + 9'd1 >= fexp[slot]) begin
                factive_next[slot] = 1'b0;
                if (fexp[slot] <= 9'(lpmq_pkg::MSG_BYTES)) begin
                  done_c = 1'b1;
                  len_we = 1'b1;
                  tail_next[slot] = lpmq_pkg::ptr_next(tail[slot]);
                  if (count[slot] >= lpmq_pkg::CNT_W'(lpmq_pkg::RING_DEPTH)) begin
                    head_next[slot] = lpmq_pkg::ptr_next(head[slot]);
                    err_next[slot]  = 1'b1;
                  end else begin
                    count_next[slot] = count[slot] + lpmq_pkg::CNT_W'(1);
                  end
                end
              end
            end
          end
        end
        lpmq_pkg::CMD_READ: begin
          if (count[slot] == '0) begin
            empty_c = 1'b1;
          end else begin
            read_c       = 1'b1;
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = {lpmq_pkg::buf_index(slot, head[slot]), value};
          end
        end
        lpmq_pkg::CMD_POP: begin
          if (count[slot] == '0) begin
            empty_c = 1'b1;
          end else begin
            head_next[slot]  = lpmq_pkg::ptr_next(head[slot]);
            count_next[slot] = count[slot] - lpmq_pkg::CNT_W'(1);
          end
        end
        lpmq_pkg::CMD_RESET, lpmq_pkg::CMD_OUTCOME: begin
          conn_next[slot]    = (cmd == lpmq_pkg::CMD_OUTCOME) && connect_ok;
          err_next[slot]     = (cmd == lpmq_pkg::CMD_OUTCOME) && !connect_ok;
          closed_next[slot]  = 1'b0;
          factive_next[slot] = 1'b0;
          fexp_next[slot]    = '0;
          frecv_next[slot]   = '0;
          head_next[slot]    = '0;
          tail_next[slot]    = '0;
          count_next[slot]   = '0;
        end
        lpmq_pkg::CMD_CLOSED: begin
          if (conn[slot]) begin
            conn_next[slot]   = 1'b0;
            closed_next[slot] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        conn[i]    <= 1'b0;
        err[i]     <= 1'b0;
        closed[i]  <= 1'b0;
        factive[i] <= 1'b0;
        fexp[i]    <= '0;
        frecv[i]   <= '0;
        head[i]    <= '0;
        tail[i]    <= '0;
        count[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < NS; i++) begin
        conn[i]    <= conn_next[i];
        err[i]     <= err_next[i];
        closed[i]  <= closed_next[i];
        factive[i] <= factive_next[i];
        fexp[i]    <= fexp_next[i];
        frecv[i]   <= frecv_next[i];
        head[i]    <= head_next[i];
        tail[i]    <= tail_next[i];
        count[i]   <= count_next[i];
      end
    end
  end

  // Length of each completed message.
  always_ff @(posedge clk) begin
    if (len_we) begin
      lengths[len_waddr] <= fexp[slot];
    end
  end

  // Word in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (load_out) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_slot_ok <= slot_ok;
      p_slot    <= slot;
      p_read    <= read_c;
      p_val     <= value;
      p_empty   <= empty_c;
      p_done    <= done_c;
    end
  end

  // Status of the slot and of all slots after the word.
  always_comb begin
    any_d = 1'b0;
    any_e = 1'b0;
    for (int i = 0; i < NS; i++) begin
      any_d = any_d | (count[i] != '0);
      any_e = any_e | err[i];
    end
    hlen = (p_slot_ok && count[p_slot] != '0) ?
           lengths[lpmq_pkg::buf_index(p_slot, head[p_slot])] : 9'd0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_byte     <= (p_read && {1'b0, p_val} < hlen) ? mem_q : 8'd0;
      head_length   <= hlen;
      queue_empty   <= p_empty;
      message_done  <= p_done;
      is_connected  <= p_slot_ok && conn[p_slot];
      data_ready    <= p_slot_ok && (count[p_slot] != '0);
      slot_fault    <= p_slot_ok && err[p_slot];
      remote_closed <= p_slot_ok && closed[p_slot];
      any_data      <= any_d;
      any_error     <= any_e;
    end
  end

  `LPMQ_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word not in flight")
  `LPMQ_ASSERT_NEXT(a_busy_one_cycle, busy && !(out_valid && out_stall), !busy,
                    "word in flight longer than one cycle without a stall")
  `LPMQ_ASSERT_SAME(a_count_bound, 1'b1,
                    count[0] <= lpmq_pkg::CNT_W'(lpmq_pkg::RING_DEPTH),
                    "slot queue count beyond ring depth")
  `LPMQ_ASSERT_NEXT(a_done_queues, load_out && p_done, out_valid && data_ready,
                    "completed message not reported as queued")

endmodule

/* test/lpmq_checker.sv */
// ---------------------------------------------------------------------------
// Length-prefixed message queue checker
// Watches both channels, keeps its own copy of every slot's deframing state
// and message ring, predicts one status word per accepted command word and
// compares each result word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module lpmq_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [1:0] slot,
  input  logic [7:0] value,
  input  logic       connect_ok,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] read_byte,
  input  logic [8:0] head_length,
  input  logic       queue_empty,
  input  logic       message_done,
  input  logic       is_connected,
  input  logic       data_ready,
  input  logic       slot_fault,
  input  logic       remote_closed,
  input  logic       any_data,
  input  logic       any_error,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSL = lpmq_pkg::SLOT_COUNT;
  localparam int RD  = lpmq_pkg::RING_DEPTH;
  localparam int MB  = lpmq_pkg::MSG_BYTES;

  typedef struct packed {
    logic [7:0] rd;
    logic [8:0] hlen;
    logic       empty;
    logic       done;
    logic       conn;
    logic       ready;
    logic       err;
    logic       closed;
    logic       anyd;
    logic       anye;
  } status_t;

  status_t status_q[$];

  // Per-slot model state.
  logic     conn_s[NSL], err_s[NSL], closed_s[NSL];
  logic     open_s[NSL];
  int       want_s[NSL], got_s[NSL];
  int       head_s[NSL], tail_s[NSL], count_s[NSL];
  logic [7:0] asm_buf[NSL][MB];
  int       len_s[NSL][RD];
  logic [7:0] ring_buf[NSL][RD][MB];

  assign pending = status_q.size();

  function automatic int ring_step(input int p);
    return (p + 1 >= RD) ? 0 : p + 1;
  endfunction

  function automatic void wipe_slot(input int s);
    conn_s[s] = 0; err_s[s] = 0; closed_s[s] = 0; open_s[s] = 0;
    want_s[s] = 0; got_s[s] = 0; head_s[s] = 0; tail_s[s] = 0; count_s[s] = 0;
  endfunction

  // Deframes one received byte; returns 1 when a message was queued.
  function automatic logic deframe(input int s, input logic [7:0] b);
    int t;
    if (!open_s[s]) begin
      want_s[s] = (b == 0) ? 256 : b;
      got_s[s] = 0;
      open_s[s] = 1;
      return 0;
    end
    if (got_s[s] < MB) asm_buf[s][got_s[s]] = b;
    got_s[s]++;
    if (got_s[s] >= want_s[s]) begin
      open_s[s] = 0;
      if (want_s[s] <= MB) begin
        // A full ring drops its oldest message and flags the slot.
        if (count_s[s] >= RD) begin
          head_s[s] = ring_step(head_s[s]);
          count_s[s]--;
          err_s[s] = 1;
        end
        t = tail_s[s];
        len_s[s][t] = want_s[s];
        for (int i = 0; i < want_s[s]; i++) ring_buf[s][t][i] = asm_buf[s][i];
        tail_s[s] = ring_step(t);
        count_s[s]++;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic status_t predict_status(input logic [2:0] c, input int s,
                                             input logic [7:0] v, input logic ok);
    status_t r;
    r = '0;
    case (c)
      lpmq_pkg::CMD_RX: if (conn_s[s]) r.done = deframe(s, v);
      lpmq_pkg::CMD_READ: begin
        if (count_s[s] == 0) r.empty = 1;
        else if (v < len_s[s][head_s[s]]) r.rd = ring_buf[s][head_s[s]][v];
      end
      lpmq_pkg::CMD_POP: begin
        if (count_s[s] == 0) r.empty = 1;
        else begin
          head_s[s] = ring_step(head_s[s]);
          count_s[s]--;
        end
      end
      lpmq_pkg::CMD_RESET: wipe_slot(s);
      lpmq_pkg::CMD_OUTCOME: begin
        wipe_slot(s);
        if (ok) conn_s[s] = 1;
        else err_s[s] = 1;
      end
      lpmq_pkg::CMD_CLOSED: if (conn_s[s]) begin
        conn_s[s] = 0;
        closed_s[s] = 1;
      end
      default: ;
    endcase
    if (count_s[s] != 0) r.hlen = 9'(len_s[s][head_s[s]]);
    r.conn = conn_s[s];
    r.ready = count_s[s] != 0;
    r.err = err_s[s];
    r.closed = closed_s[s];
    for (int k = 0; k < NSL; k++) begin
      if (count_s[k] != 0) r.anyd = 1;
      if (err_s[k]) r.anye = 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    for (int s = 0; s < NSL; s++) wipe_slot(s);
  end

  // Predict on input words and compare output words, both sampled at the edge.
  always @(posedge clk) begin
    status_t e;
    if (!rst) begin
      if (in_valid && !in_stall)
        status_q.push_back(predict_status(cmd, int'(slot), value, connect_ok));
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = status_q.pop_front();
          if (read_byte !== e.rd) report_mismatch("read_byte", read_byte, e.rd);
          if (head_length !== e.hlen) report_mismatch("head_length", head_length, e.hlen);
          if (queue_empty !== e.empty) report_mismatch("queue_empty", queue_empty, e.empty);
          if (message_done !== e.done) report_mismatch("message_done", message_done, e.done);
          if (is_connected !== e.conn) report_mismatch("is_connected", is_connected, e.conn);
          if (data_ready !== e.ready) report_mismatch("data_ready", data_ready, e.ready);
          if (slot_fault !== e.err) report_mismatch("slot_fault", slot_fault, e.err);
          if (remote_closed !== e.closed)
            report_mismatch("remote_closed", remote_closed, e.closed);
          if (any_data !== e.anyd) report_mismatch("any_data", any_data, e.anyd);
          if (any_error !== e.anye) report_mismatch("any_error", any_error, e.anye);
        end
      end
    end
  end
endmodule

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// Length-prefixed message queue testbench
// Drives directed and random command words: mostly well-formed framed
// messages on connected slots with reads and pops, plus noise, and lets the
// checker judge every result word under varying sender and receiver idling.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 0, rst = 1;
  logic       in_valid = 0, in_stall;
  logic [2:0] cmd = '0;
  logic [1:0] slot = '0;
  logic [7:0] value = '0;
  logic       connect_ok = 0;
  logic       out_valid, out_stall = 0;
  logic [7:0] read_byte;
  logic [8:0] head_length;
  logic       queue_empty, message_done, is_connected, data_ready;
  logic       slot_fault, remote_closed, any_data, any_error;
  int         fail_count, pending;
  int         send_idle_pct = 36, recv_idle_pct = 55;
  logic       hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  length_prefixed_message_queue_core u_top (.*);
  lpmq_checker u_check (.*);

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offers one word and waits for it to be taken, idling at random first.
  task automatic send_word(input logic [2:0] c, input logic [1:0] s,
                           input logic [7:0] v, input logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; slot <= s; value <= v; connect_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A framed message of n bytes (256 sent as a zero prefix).
  task automatic send_frame(input logic [1:0] s, input int n);
    send_word(lpmq_pkg::CMD_RX, s, 8'(n), 1'b0);
    for (int i = 0; i < n; i++)
      send_word(lpmq_pkg::CMD_RX, s, 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic random_word();
    logic [1:0] s;
    int sel, n;
    s = 2'($urandom_range(3));
    sel = $urandom_range(99);
    if (sel < 35) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
      send_frame(s, n);
    end else if (sel < 55) send_word(lpmq_pkg::CMD_READ, s, 8'($urandom_range(7)), 1'b0);
    else if (sel < 62) send_word(lpmq_pkg::CMD_READ, s, 8'($urandom_range(255)), 1'b0);
    else if (sel < 72) send_word(lpmq_pkg::CMD_POP, s, 8'd0, 1'b0);
    else if (sel < 80)
      send_word(lpmq_pkg::CMD_OUTCOME, s, 8'd0, $urandom_range(3) != 0);
    else if (sel < 84) send_word(lpmq_pkg::CMD_RESET, s, 8'($urandom), 1'($urandom));
    else if (sel < 88) send_word(lpmq_pkg::CMD_CLOSED, s, 8'($urandom), 1'($urandom));
    else if (sel < 91) send_word(3'($urandom_range(6, 7)), s, 8'($urandom), 1'($urandom));
    else send_word(lpmq_pkg::CMD_RX, s, 8'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes of the fields and each special case.
    send_word(lpmq_pkg::CMD_RX, 2'd0, 8'hff, 1'b1);      // byte while not connected
    send_word(lpmq_pkg::CMD_READ, 2'd1, 8'd0, 1'b0);     // read on empty queue
    send_word(lpmq_pkg::CMD_POP, 2'd1, 8'd0, 1'b0);      // pop on empty queue
    send_word(lpmq_pkg::CMD_CLOSED, 2'd2, 8'd0, 1'b0);   // close while not connected
    send_word(lpmq_pkg::CMD_OUTCOME, 2'd3, 8'd0, 1'b0);  // failed connect
    send_word(3'd6, 2'd0, 8'h55, 1'b0);
    send_word(3'd7, 2'd3, 8'haa, 1'b1);
    send_word(lpmq_pkg::CMD_OUTCOME, 2'd0, 8'd0, 1'b1);
    send_frame(2'd0, 256);                               // zero prefix means a full message
    send_word(lpmq_pkg::CMD_READ, 2'd0, 8'd255, 1'b0);
    send_word(lpmq_pkg::CMD_READ, 2'd0, 8'd0, 1'b0);
    send_frame(2'd0, 1);
    send_word(lpmq_pkg::CMD_POP, 2'd0, 8'd0, 1'b0);
    send_word(lpmq_pkg::CMD_READ, 2'd0, 8'd1, 1'b0);     // index beyond head length
    for (int i = 0; i < 5; i++) send_frame(2'd0, 2);     // overflow drops oldest
    send_word(lpmq_pkg::CMD_CLOSED, 2'd0, 8'd0, 1'b0);
    send_word(lpmq_pkg::CMD_RESET, 2'd3, 8'd0, 1'b0);
    // Random phases: three idling mixes.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 55; recv_idle_pct = 36; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int s = 0; s < lpmq_pkg::SLOT_COUNT; s++)
        send_word(lpmq_pkg::CMD_OUTCOME, 2'(s), 8'd0, 1'b1);
      for (int i = 0; i < 56; i++) random_word();
      if (ph == 0) begin
        // Long receiver hold-off while words keep coming.
        fork
          begin
            hold_off = 1;
            repeat (60) @(posedge clk);
            hold_off = 0;
          end
          for (int i = 0; i < 10; i++)
            send_word(lpmq_pkg::CMD_READ, 2'd0, 8'($urandom), 1'b0);
        join
        drain();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
